/* rtl/bezier_de_casteljau_subdivide_unit_macros.svh */
// assertion macros shared by the bezier subdivision rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef BEZIER_DE_CASTELJAU_SUBDIVIDE_UNIT_MACROS_SVH
`define BEZIER_DE_CASTELJAU_SUBDIVIDE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bdc_pkg.sv */
// shared constants, types and state codes for the bezier subdivision unit
// no dependencies
`timescale 1ns / 1ps

package bdc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int COORD_W    = 24;
    localparam int PT_W       = 2 * COORD_W;
    localparam int T_W        = 17;
    localparam int T_FRAC     = 16;
    localparam int PIDX_W     = 4;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int RES_DEPTH  = 2 * MAX_POINTS;
    localparam int RES_AW     = IDX_W + 1;
    localparam int PROD_W     = COORD_W + 1 + T_W + 1;

    localparam logic [T_W-1:0]    T_ONE    = T_W'(1 << T_FRAC);
    localparam logic [T_W-1:0]    T_RESET  = T_W'(1 << (T_FRAC - 1));
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_POINTS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_POINTS - 1);
    localparam logic [PROD_W-1:0] ROUND    = PROD_W'(1 << (T_FRAC - 1));

    // x in the low half, y in the high half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD0,
        S_LOAD0_W,
        S_LOADN_W,
        S_LEV_RD0,
        S_LEV_LEFT,
        S_LERP_MUL,
        S_LERP_WR,
        S_LERP_WR2,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

endpackage

/* rtl/bezier_de_casteljau_subdivide_unit.sv */
// Bezier curve subdivision by de Casteljau's triangle, in place in a point ram.
// Control points stream in on the input channel; the point marked last_point
// starts the triangle. For n+1 stored points the block emits 2(n+1) results:
// for each i the first-half point (level i, index 0), then the second-half
// point (level n-i, index i). The first-half point with index n is the curve
// value at 1-t, as t weights the lower-index point. A point that arrives while
// 16 are stored is dropped and every result of that run carries overflow.
// t_weight is written on the cfg channel (Q1.16, values above 1.0 are taken as
// 1.0); cfg_ready is always high. Points are accepted one per cycle while idle.
// After the last point the input stalls until the last result is loaded: each
// lerp takes a multiply and a write state, and results leave a result ram by a
// read and a load state. The output register holds a result while out_ready is
// low; the sequencer then waits and no later result is lost.
// Reset clears the point count, the drop flag and the output valid, and sets
// t to 0.5; ram contents are not cleared.
// depends on bdc_pkg, bdc_ram, bdc_lerp and the macros header
`timescale 1ns / 1ps
`include "bezier_de_casteljau_subdivide_unit_macros.svh"

module bezier_de_casteljau_subdivide_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdc_pkg::T_W-1:0]             t_weight,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bdc_pkg::COORD_W-1:0]  point_x,
    input  logic signed [bdc_pkg::COORD_W-1:0]  point_y,
    input  logic                                last_point,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bdc_pkg::COORD_W-1:0]  out_x,
    output logic signed [bdc_pkg::COORD_W-1:0]  out_y,
    output logic                                second_half,
    output logic [bdc_pkg::PIDX_W-1:0]          point_index,
    output logic                                overflow,
    output logic                                last_result
);

    bdc_pkg::state_t                   state_reg, state_next;
    logic [bdc_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                              dropped_reg, dropped_next;
    logic                              ovf_reg, ovf_next;
    logic [bdc_pkg::T_W-1:0]           t_reg;
    logic [bdc_pkg::IDX_W-1:0]         n_reg, n_next;
    logic [bdc_pkg::IDX_W-1:0]         lev_reg, lev_next;
    logic [bdc_pkg::IDX_W-1:0]         k_reg, k_next;
    logic [bdc_pkg::RES_AW-1:0]        j_reg, j_next;
    bdc_pkg::point_t                   left_reg, left_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [bdc_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic                              second_half_reg;
    logic [bdc_pkg::PIDX_W-1:0]        point_index_reg;
    logic                              overflow_reg;
    logic                              last_result_reg;
    logic                              out_load;

    logic                              pt_we, pt_re;
    logic [bdc_pkg::IDX_W-1:0]         pt_waddr, pt_raddr;
    logic [bdc_pkg::PT_W-1:0]          pt_wdata, pt_rdata;
    logic                              res_we, res_re;
    logic [bdc_pkg::RES_AW-1:0]        res_waddr, res_raddr;
    logic [bdc_pkg::PT_W-1:0]          res_wdata, res_rdata;
    bdc_pkg::point_t                   in_pt, res_pt, lerp_pt;

    logic                              in_fire, out_fire, store_ok;
    logic                              mul_en, k_last;
    logic [bdc_pkg::IDX_W-1:0]         rem;
    logic [bdc_pkg::RES_AW-1:0]        last_j;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == bdc_pkg::S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;
    assign store_ok  = (count_reg < bdc_pkg::MAX_CNT);
    assign rem       = n_reg - lev_reg;
    assign k_last    = (k_reg == rem);
    assign last_j    = {n_reg, 1'b1};
    assign in_pt.x   = point_x;
    assign in_pt.y   = point_y;
    assign res_pt    = bdc_pkg::point_t'(res_rdata);

    bdc_ram #(
        .WIDTH (bdc_pkg::PT_W),
        .DEPTH (bdc_pkg::MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    bdc_ram #(
        .WIDTH (bdc_pkg::PT_W),
        .DEPTH (bdc_pkg::RES_DEPTH)
    ) u_result_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .re    (res_re),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    bdc_lerp u_lerp (
        .clk       (clk),
        .mul_en    (mul_en),
        .left_pt   (left_reg),
        .right_pt  (bdc_pkg::point_t'(pt_rdata)),
        .t_val     (t_reg),
        .result_pt (lerp_pt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdc_pkg::S_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            t_reg         <= bdc_pkg::T_RESET;
            n_reg         <= '0;
            lev_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            lev_reg       <= lev_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                t_reg <= (t_weight > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE : t_weight;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        if (out_load)
        begin
            out_x_reg       <= res_pt.x;
            out_y_reg       <= res_pt.y;
            second_half_reg <= j_reg[0];
            point_index_reg <= bdc_pkg::PIDX_W'(j_reg[bdc_pkg::RES_AW-1:1]);
            overflow_reg    <= ovf_reg;
            last_result_reg <= (j_reg == last_j);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        lev_next       = lev_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        left_next      = left_reg;
        out_load       = 1'b0;
        mul_en         = 1'b0;
        pt_we          = 1'b0;
        pt_waddr       = k_reg;
        pt_wdata       = lerp_pt;
        pt_re          = 1'b0;
        pt_raddr       = '0;
        res_we         = 1'b0;
        res_waddr      = {lev_reg, 1'b0};
        res_wdata      = lerp_pt;
        res_re         = 1'b0;
        res_raddr      = j_reg;

        case (state_reg)
            bdc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (store_ok)
                    begin
                        pt_we      = 1'b1;
                        pt_waddr   = count_reg[bdc_pkg::IDX_W-1:0];
                        pt_wdata   = in_pt;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_point)
                    begin
                        n_next       = store_ok ? count_reg[bdc_pkg::IDX_W-1:0]
                                                : bdc_pkg::LAST_IDX;
                        ovf_next     = dropped_reg | ~store_ok;
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = bdc_pkg::S_LOAD0;
                    end
                end
            end
            bdc_pkg::S_LOAD0:
            begin
                pt_re      = 1'b1;
                state_next = bdc_pkg::S_LOAD0_W;
            end
            bdc_pkg::S_LOAD0_W:
            begin
                // level 0, index 0 is the first result
                res_we     = 1'b1;
                res_waddr  = '0;
                res_wdata  = pt_rdata;
                pt_re      = 1'b1;
                pt_raddr   = n_reg;
                state_next = bdc_pkg::S_LOADN_W;
            end
            bdc_pkg::S_LOADN_W:
            begin
                // level 0, index n is the last result
                res_we    = 1'b1;
                res_waddr = last_j;
                res_wdata = pt_rdata;
                if (n_reg == '0)
                begin
                    j_next     = '0;
                    state_next = bdc_pkg::S_OUT_RD;
                end
                else
                begin
                    lev_next   = bdc_pkg::IDX_W'(1);
                    state_next = bdc_pkg::S_LEV_RD0;
                end
            end
            bdc_pkg::S_LEV_RD0:
            begin
                pt_re      = 1'b1;
                k_next     = '0;
                state_next = bdc_pkg::S_LEV_LEFT;
            end
            bdc_pkg::S_LEV_LEFT:
            begin
                left_next  = pt_rdata;
                pt_re      = 1'b1;
                pt_raddr   = bdc_pkg::IDX_W'(1);
                state_next = bdc_pkg::S_LERP_MUL;
            end
            bdc_pkg::S_LERP_MUL:
            begin
                mul_en     = 1'b1;
                state_next = bdc_pkg::S_LERP_WR;
            end
            bdc_pkg::S_LERP_WR:
            begin
                pt_we     = 1'b1;
                // old entry k+1 becomes the left operand of the next lerp
                left_next = pt_rdata;
                if (k_reg == '0)
                begin
                    res_we = 1'b1;
                end
                else if (k_last)
                begin
                    res_we    = 1'b1;
                    res_waddr = {k_reg, 1'b1};
                end
                if (k_last)
                begin
                    if (k_reg == '0)
                    begin
                        state_next = bdc_pkg::S_LERP_WR2;
                    end
                    else
                    begin
                        lev_next   = lev_reg + 1'b1;
                        state_next = bdc_pkg::S_LEV_RD0;
                    end
                end
                else
                begin
                    pt_re      = 1'b1;
                    pt_raddr   = k_reg + bdc_pkg::IDX_W'(2);
                    k_next     = k_reg + 1'b1;
                    state_next = bdc_pkg::S_LERP_MUL;
                end
            end
            bdc_pkg::S_LERP_WR2:
            begin
                // top of the triangle: also the second-half point with index 0
                res_we     = 1'b1;
                res_waddr  = {k_reg, 1'b1};
                j_next     = '0;
                state_next = bdc_pkg::S_OUT_RD;
            end
            bdc_pkg::S_OUT_RD:
            begin
                res_re     = 1'b1;
                state_next = bdc_pkg::S_OUT_LD;
            end
            bdc_pkg::S_OUT_LD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (j_reg == last_j)
                    begin
                        state_next = bdc_pkg::S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = bdc_pkg::S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = bdc_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign second_half = second_half_reg;
    assign point_index = point_index_reg;
    assign overflow    = overflow_reg;
    assign last_result = last_result_reg;

    `BDC_ASSERT_NOW(a_pt_no_rw_clash, pt_we && pt_re, pt_waddr != pt_raddr,
        "point ram read and write hit the same entry")
    `BDC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= bdc_pkg::MAX_CNT,
        "point count beyond store size")
    `BDC_ASSERT_NEXT(a_run_clears_count, in_fire && last_point,
        count_reg == '0 && !dropped_reg, "run start did not clear count and drop flag")
    `BDC_ASSERT_NOW(a_lerp_in_level, state_reg == bdc_pkg::S_LERP_WR,
        k_reg <= rem, "lerp index past the end of its level")
    `BDC_ASSERT_NEXT(a_no_result_overwrite, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_x_reg) && $stable(last_result_reg),
        "pending result overwritten while stalled")

endmodule

/* rtl/bdc_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bdc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bdc_lerp.sv */
// fixed point lerp of two points: right + round(t * (left - right))
// depends on bdc_pkg; product registered, rounding add follows
`timescale 1ns / 1ps

module bdc_lerp (
    input  logic                       clk,
    input  logic                       mul_en,
    input  bdc_pkg::point_t            left_pt,
    input  bdc_pkg::point_t            right_pt,
    input  logic [bdc_pkg::T_W-1:0]    t_val,
    output bdc_pkg::point_t            result_pt
);

    logic signed [bdc_pkg::COORD_W:0]    diff_x;
    logic signed [bdc_pkg::COORD_W:0]    diff_y;
    logic signed [bdc_pkg::T_W:0]        t_signed;
    logic signed [bdc_pkg::PROD_W-1:0]   prod_x_next;
    logic signed [bdc_pkg::PROD_W-1:0]   prod_y_next;
    logic signed [bdc_pkg::PROD_W-1:0]   prod_x_reg;
    logic signed [bdc_pkg::PROD_W-1:0]   prod_y_reg;
    bdc_pkg::point_t                     right_reg;
    logic [bdc_pkg::PROD_W-1:0]          sum_x;
    logic [bdc_pkg::PROD_W-1:0]          sum_y;

    always_comb
    begin
        diff_x      = {left_pt.x[bdc_pkg::COORD_W-1], left_pt.x}
                    - {right_pt.x[bdc_pkg::COORD_W-1], right_pt.x};
        diff_y      = {left_pt.y[bdc_pkg::COORD_W-1], left_pt.y}
                    - {right_pt.y[bdc_pkg::COORD_W-1], right_pt.y};
        t_signed    = {1'b0, t_val};
        prod_x_next = diff_x * t_signed;
        prod_y_next = diff_y * t_signed;
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            right_reg  <= right_pt;
        end
    end

    // floor((p + half) / 2^16); bits above the result width drop out
    always_comb
    begin
        sum_x       = prod_x_reg + bdc_pkg::ROUND;
        sum_y       = prod_y_reg + bdc_pkg::ROUND;
        result_pt.x = right_reg.x
                    + sum_x[bdc_pkg::T_FRAC+bdc_pkg::COORD_W-1:bdc_pkg::T_FRAC];
        result_pt.y = right_reg.y
                    + sum_y[bdc_pkg::T_FRAC+bdc_pkg::COORD_W-1:bdc_pkg::T_FRAC];
    end

endmodule
